FILE: design/matrix_inverse_adjugate_defines.svh
// assertion macros for the matrix inverse block
`ifndef MATRIX_INVERSE_ADJUGATE_DEFINES_SVH
`define MATRIX_INVERSE_ADJUGATE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MIA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MIA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/mia_pkg.sv
package mia_pkg;

  localparam int MAX_DIM     = 4;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int DATA_W      = 32;
  localparam int SLOT_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int DIM_W       = 3;
  localparam int ACC_W       = 136;
  localparam int STEP_W      = 8;

  typedef logic [ACC_W-1:0] acc_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE, ST_C_INIT, ST_C_MUL1, ST_C_LOADX, ST_C_MUL2, ST_D_LOADX, ST_D_MUL,
    ST_DQ_ADD, ST_DQ_SAT, ST_D_ABS, ST_CHECK, ST_E_ABS, ST_E_BUILD, ST_E_DIV,
    ST_E_OUT
  } state_t;

  // status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_SINGULAR = 2'd1;
  localparam logic [1:0] STAT_SAT      = 2'd2;

  // register indexes
  localparam logic CFG_MATRIX_SIZE = 1'b0;
  localparam logic CFG_THRESHOLD   = 1'b1;

  // column of the 3x3 minor used at position pos by permutation p
  function automatic logic [1:0] perm_col(input logic [2:0] p, input logic [1:0] pos);
    logic [5:0] cols;
    begin
      unique case (p)
        3'd0: cols = {2'd2, 2'd1, 2'd0};
        3'd1: cols = {2'd0, 2'd2, 2'd1};
        3'd2: cols = {2'd1, 2'd0, 2'd2};
        3'd3: cols = {2'd1, 2'd2, 2'd0};
        3'd4: cols = {2'd0, 2'd1, 2'd2};
        3'd5: cols = {2'd2, 2'd0, 2'd1};
        default: cols = {2'd2, 2'd1, 2'd0};
      endcase
      unique case (pos)
        2'd0: perm_col = cols[1:0];
        2'd1: perm_col = cols[3:2];
        default: perm_col = cols[5:4];
      endcase
    end
  endfunction

  // odd permutations
  function automatic logic perm_neg(input logic [2:0] p);
    perm_neg = (p == 3'd3) || (p == 3'd4) || (p == 3'd5);
  endfunction

  // index k of the remaining rows or columns after removing one
  function automatic logic [1:0] skip_idx(input logic [1:0] k, input logic [1:0] removed);
    skip_idx = (k >= removed) ? k + 2'd1 : k;
  endfunction

endpackage

FILE: design/matrix_inverse_adjugate.sv
// order: the determinant first, then, unless it is singular, each inverse element in turn
//   (n*n elements); every product and the restoring division go through one
//   136-bit adder, one multiplier bit or one quotient bit a cycle
// throughput: one element beat per cycle while loading; busy stays high until the last
//   result; the receiver cannot stall, each result strobes for one cycle
// reset: synchronous active-low rst_n clears the sequencer, load count, size (4) and
//   threshold (1); the matrix store is not cleared
`include "matrix_inverse_adjugate_defines.svh"
module matrix_inverse_adjugate import mia_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_element_value,
  input  logic               in_final_element,
  output logic               out_valid,
  output logic signed [31:0] out_inverse_value,
  output logic [1:0]         out_row_index,
  output logic [1:0]         out_column_index,
  output logic signed [63:0] out_determinant_value,
  output logic [1:0]         out_status_code,
  output logic               out_final_result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] load_cnt_r, load_cnt_nxt;
  logic [DIM_W-1:0] size_r, dim_r, dim_nxt;
  logic [31:0] thr_r;
  logic [1:0] ci_r, ci_nxt, cj_r, cj_nxt, er_r, er_nxt, ec_r, ec_nxt;
  logic [2:0] perm_r, perm_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic mode_r, mode_nxt;
  acc_t x_r, x_nxt, t_r, t_nxt, cof_r, cof_nxt, det_r, det_nxt, dabs_r, dabs_nxt;
  logic [63:0] det64_r, det64_nxt;
  logic [31:0] q_r, q_nxt;
  logic qov_r, qov_nxt, neg_r, neg_nxt;
  logic [DATA_W-1:0] matrix_store_r [STORE_DEPTH];
  logic wr_en;

  logic ov_r, ov_nxt;
  logic [31:0] oval_r, oval_nxt;
  logic [1:0] orow_r, orow_nxt, ocol_r, ocol_nxt, ostat_r, ostat_nxt;
  logic [63:0] odet_r, odet_nxt;
  logic ofin_r, ofin_nxt;

  logic [1:0] rd_row, rd_col;
  logic [4:0] slot_full;
  logic rd_pad;
  logic [DATA_W-1:0] elem_r;
  acc_t opa, opb, sum, sh, round_c, rem_sh;
  logic sub, ebit, mul_last, term_neg, fits, singular, qbit, sat, last_elem;
  logic [63:0] mag64;
  logic [31:0] lim;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= DIM_W'(MAX_DIM);
      thr_r  <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MATRIX_SIZE: size_r <= cfg_data[DIM_W-1:0];
        CFG_THRESHOLD:   thr_r  <= cfg_data;
      endcase
    end
  end

  // matrix store
  assign wr_en = (state_r == ST_IDLE) && start && (load_cnt_r < CNT_W'(STORE_DEPTH));
  always_ff @(posedge clk) begin
    if (wr_en) begin
      matrix_store_r[load_cnt_r[SLOT_W-1:0]] <= in_element_value;
    end
  end

  // element address for the next cycle, padded to 4x4 with raw ones on the diagonal
  always_comb begin
    unique case (state_nxt)
      ST_C_INIT: begin
        rd_row = skip_idx(2'd0, ci_nxt);
        rd_col = skip_idx(perm_col(perm_nxt, 2'd0), cj_nxt);
      end
      ST_C_MUL1: begin
        rd_row = skip_idx(2'd1, ci_nxt);
        rd_col = skip_idx(perm_col(perm_nxt, 2'd1), cj_nxt);
      end
      ST_C_MUL2: begin
        rd_row = skip_idx(2'd2, ci_nxt);
        rd_col = skip_idx(perm_col(perm_nxt, 2'd2), cj_nxt);
      end
      ST_D_MUL: begin
        rd_row = 2'd0;
        rd_col = cj_nxt;
      end
      default: begin
        rd_row = 2'd0;
        rd_col = 2'd0;
      end
    endcase
    slot_full = 5'(rd_row) * 5'(dim_nxt) + 5'(rd_col);
    rd_pad    = !((DIM_W'(rd_row) < dim_nxt) && (DIM_W'(rd_col) < dim_nxt));
  end

  // registered element read, the beat being written is forwarded
  always_ff @(posedge clk) begin
    if (rd_pad) begin
      elem_r <= (rd_row == rd_col) ? 32'd1 : 32'd0;
    end else if (wr_en && (load_cnt_r[SLOT_W-1:0] == slot_full[SLOT_W-1:0])) begin
      elem_r <= in_element_value;
    end else begin
      elem_r <= matrix_store_r[slot_full[SLOT_W-1:0]];
    end
  end

  assign ebit     = elem_r[step_r[4:0]];
  assign mul_last = (step_r[4:0] == 5'd31);
  assign term_neg = perm_neg(perm_r) ^ ci_r[0] ^ cj_r[0];
  assign rem_sh   = {t_r[ACC_W-2:0], x_r[ACC_W-1]};

  // rounding constant for the q32.32 conversion
  always_comb begin
    unique case (dim_r)
      3'd3:    round_c = acc_t'(1) << 15;
      3'd4:    round_c = acc_t'(1) << 31;
      default: round_c = '0;
    endcase
  end

  // operand select for the shared adder
  always_comb begin
    opa = '0;
    opb = '0;
    sub = 1'b0;
    unique case (state_r)
      ST_C_MUL1: begin
        opa = t_r;   opb = x_r;   sub = mul_last;
      end
      ST_C_MUL2: begin
        opa = cof_r; opb = x_r;   sub = mul_last ^ term_neg;
      end
      ST_D_MUL: begin
        opa = det_r; opb = x_r;   sub = mul_last;
      end
      ST_DQ_ADD: begin
        opa = det_r; opb = round_c;
      end
      ST_D_ABS: begin
        opb = det_r; sub = 1'b1;
      end
      ST_E_ABS: begin
        opb = cof_r; sub = 1'b1;
      end
      ST_E_BUILD: begin
        opa = cof_r << 33; opb = dabs_r;
      end
      ST_E_DIV: begin
        opa = rem_sh; opb = dabs_r << 1; sub = 1'b1;
      end
      default: begin
        sub = 1'b0;
      end
    endcase
  end

  mia_addsub u_addsub (
    .opa (opa),
    .opb (opb),
    .sub (sub),
    .sum (sum)
  );

  // determinant scaling and saturation
  always_comb begin
    unique case (dim_r)
      3'd1:    sh = t_r << 16;
      3'd3:    sh = acc_t'($signed(t_r) >>> 16);
      3'd4:    sh = acc_t'($signed(t_r) >>> 32);
      default: sh = t_r;
    endcase
    fits = (&sh[ACC_W-1:63]) || !(|sh[ACC_W-1:63]);
  end

  assign mag64    = det64_r[63] ? (~det64_r + 64'd1) : det64_r;
  assign singular = (mag64 <= {32'd0, thr_r}) || (dabs_r == '0);
  assign qbit     = !sum[ACC_W-1];
  assign lim      = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign sat      = qov_r || (q_r > lim);
  assign last_elem = (DIM_W'(er_r) == dim_r - 3'd1) && (DIM_W'(ec_r) == dim_r - 3'd1);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    dim_nxt      = dim_r;
    ci_nxt       = ci_r;
    cj_nxt       = cj_r;
    er_nxt       = er_r;
    ec_nxt       = ec_r;
    perm_nxt     = perm_r;
    step_nxt     = step_r;
    mode_nxt     = mode_r;
    x_nxt        = x_r;
    t_nxt        = t_r;
    cof_nxt      = cof_r;
    det_nxt      = det_r;
    dabs_nxt     = dabs_r;
    det64_nxt    = det64_r;
    q_nxt        = q_r;
    qov_nxt      = qov_r;
    neg_nxt      = neg_r;
    ov_nxt       = 1'b0;
    oval_nxt     = oval_r;
    orow_nxt     = orow_r;
    ocol_nxt     = ocol_r;
    odet_nxt     = odet_r;
    ostat_nxt    = ostat_r;
    ofin_nxt     = ofin_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (load_cnt_r < CNT_W'(STORE_DEPTH)) begin
            load_cnt_nxt = load_cnt_r + CNT_W'(1);
          end
          if (in_final_element) begin
            load_cnt_nxt = '0;
            if (size_r == '0) begin
              dim_nxt = DIM_W'(1);
            end else if (size_r > DIM_W'(MAX_DIM)) begin
              dim_nxt = DIM_W'(MAX_DIM);
            end else begin
              dim_nxt = size_r;
            end
            det_nxt   = '0;
            cof_nxt   = '0;
            ci_nxt    = 2'd0;
            cj_nxt    = 2'd0;
            perm_nxt  = 3'd0;
            mode_nxt  = 1'b0;
            state_nxt = ST_C_INIT;
          end
        end
      end
      // one term of a 3x3 minor: three elements, two serial products
      ST_C_INIT: begin
        x_nxt     = {{(ACC_W-DATA_W){elem_r[DATA_W-1]}}, elem_r};
        t_nxt     = '0;
        step_nxt  = '0;
        state_nxt = ST_C_MUL1;
      end
      ST_C_MUL1: begin
        if (ebit) t_nxt = sum;
        x_nxt    = x_r << 1;
        step_nxt = step_r + STEP_W'(1);
        if (mul_last) state_nxt = ST_C_LOADX;
      end
      ST_C_LOADX: begin
        x_nxt     = t_r;
        step_nxt  = '0;
        state_nxt = ST_C_MUL2;
      end
      ST_C_MUL2: begin
        if (ebit) cof_nxt = sum;
        x_nxt    = x_r << 1;
        step_nxt = step_r + STEP_W'(1);
        if (mul_last) begin
          if (perm_r == 3'd5) begin
            state_nxt = mode_r ? ST_E_ABS : ST_D_LOADX;
          end else begin
            perm_nxt  = perm_r + 3'd1;
            state_nxt = ST_C_INIT;
          end
        end
      end
      // first-row expansion of the determinant
      ST_D_LOADX: begin
        x_nxt     = cof_r;
        step_nxt  = '0;
        state_nxt = ST_D_MUL;
      end
      ST_D_MUL: begin
        if (ebit) det_nxt = sum;
        x_nxt    = x_r << 1;
        step_nxt = step_r + STEP_W'(1);
        if (mul_last) begin
          if (cj_r == 2'd3) begin
            state_nxt = ST_DQ_ADD;
          end else begin
            cj_nxt    = cj_r + 2'd1;
            perm_nxt  = 3'd0;
            cof_nxt   = '0;
            state_nxt = ST_C_INIT;
          end
        end
      end
      ST_DQ_ADD: begin
        t_nxt     = sum;
        state_nxt = ST_DQ_SAT;
      end
      ST_DQ_SAT: begin
        if (fits) begin
          det64_nxt = sh[63:0];
        end else begin
          det64_nxt = sh[ACC_W-1] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end
        state_nxt = ST_D_ABS;
      end
      ST_D_ABS: begin
        dabs_nxt  = det_r[ACC_W-1] ? sum : det_r;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (singular) begin
          ov_nxt    = 1'b1;
          oval_nxt  = '0;
          orow_nxt  = 2'd0;
          ocol_nxt  = 2'd0;
          odet_nxt  = det64_r;
          ostat_nxt = STAT_SINGULAR;
          ofin_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          er_nxt    = 2'd0;
          ec_nxt    = 2'd0;
          ci_nxt    = 2'd0;
          cj_nxt    = 2'd0;
          perm_nxt  = 3'd0;
          cof_nxt   = '0;
          mode_nxt  = 1'b1;
          state_nxt = ST_C_INIT;
        end
      end
      // inverse element: rounded |cofactor| * 2^32 / |det|
      ST_E_ABS: begin
        neg_nxt = cof_r[ACC_W-1] ^ det_r[ACC_W-1];
        if (cof_r[ACC_W-1]) cof_nxt = sum;
        state_nxt = ST_E_BUILD;
      end
      ST_E_BUILD: begin
        x_nxt     = sum;
        t_nxt     = '0;
        q_nxt     = '0;
        qov_nxt   = 1'b0;
        step_nxt  = '0;
        state_nxt = ST_E_DIV;
      end
      ST_E_DIV: begin
        t_nxt    = qbit ? sum : rem_sh;
        x_nxt    = x_r << 1;
        q_nxt    = {q_r[30:0], qbit};
        qov_nxt  = qov_r | q_r[31];
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(ACC_W - 1)) state_nxt = ST_E_OUT;
      end
      ST_E_OUT: begin
        ov_nxt    = 1'b1;
        oval_nxt  = sat ? lim : (neg_r ? (~q_r + 32'd1) : q_r);
        orow_nxt  = er_r;
        ocol_nxt  = ec_r;
        odet_nxt  = det64_r;
        ostat_nxt = sat ? STAT_SAT : STAT_OK;
        ofin_nxt  = last_elem;
        if (last_elem) begin
          state_nxt = ST_IDLE;
        end else begin
          if (DIM_W'(ec_r) == dim_r - 3'd1) begin
            ec_nxt = 2'd0;
            er_nxt = er_r + 2'd1;
          end else begin
            ec_nxt = ec_r + 2'd1;
          end
          ci_nxt    = ec_nxt;
          cj_nxt    = er_nxt;
          perm_nxt  = 3'd0;
          cof_nxt   = '0;
          state_nxt = ST_C_INIT;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      load_cnt_r <= '0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      ov_r       <= ov_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    dim_r   <= dim_nxt;
    ci_r    <= ci_nxt;
    cj_r    <= cj_nxt;
    er_r    <= er_nxt;
    ec_r    <= ec_nxt;
    perm_r  <= perm_nxt;
    step_r  <= step_nxt;
    mode_r  <= mode_nxt;
    x_r     <= x_nxt;
    t_r     <= t_nxt;
    cof_r   <= cof_nxt;
    det_r   <= det_nxt;
    dabs_r  <= dabs_nxt;
    det64_r <= det64_nxt;
    q_r     <= q_nxt;
    qov_r   <= qov_nxt;
    neg_r   <= neg_nxt;
    oval_r  <= oval_nxt;
    orow_r  <= orow_nxt;
    ocol_r  <= ocol_nxt;
    odet_r  <= odet_nxt;
    ostat_r <= ostat_nxt;
    ofin_r  <= ofin_nxt;
  end

  // result beat
  assign out_valid             = ov_r;
  assign out_inverse_value     = oval_r;
  assign out_row_index         = orow_r;
  assign out_column_index      = ocol_r;
  assign out_determinant_value = odet_r;
  assign out_status_code       = ostat_r;
  assign out_final_result      = ofin_r;

  // checks
  `MIA_ASSERT_NXT(a_strobe_single, out_valid, !out_valid, "result strobe held two cycles")
  `MIA_ASSERT_IMP(a_busy_on_final, $rose(busy), $past(start && in_final_element), "busy without final beat")
  `MIA_ASSERT_IMP(a_singular_last, out_valid && (out_status_code == STAT_SINGULAR), out_final_result && !busy, "singular result not last")

endmodule

FILE: design/mia_addsub.sv
// shared wide adder / subtractor
module mia_addsub import mia_pkg::*; (
  input  acc_t opa,
  input  acc_t opb,
  input  logic sub,
  output acc_t sum
);

  assign sum = opa + (opb ^ {ACC_W{sub}}) + acc_t'(sub);

endmodule

FILE: bench/tb_matrix_inverse_adjugate.sv
`default_nettype none
module tb_matrix_inverse_adjugate;
  import mia_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [31:0] value;
    logic               last;
  } element_beat_t;

  typedef struct {
    logic signed [31:0] inv;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [63:0] det;
    logic [1:0]         status;
    logic               last;
  } inverse_beat_t;

  localparam int WATCHDOG_LIMIT = 40000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [31:0] in_element_value;
  logic in_final_element;
  logic out_valid;
  logic signed [31:0] out_inverse_value;
  logic [1:0] out_row_index;
  logic [1:0] out_column_index;
  logic signed [63:0] out_determinant_value;
  logic [1:0] out_status_code;
  logic out_final_result;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [31:0] cfg_data;

  matrix_inverse_adjugate dut (.*);

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  element_beat_t pending_elems[$];
  inverse_beat_t expected_inv[$];
  int fail_count = 0;
  int elems_queued = 0;
  bit steady = 1'b0;
  int quiet_cycles = 0;

  // predictor state
  logic [31:0] shadow_store [STORE_DEPTH];
  int          shadow_count = 0;
  logic [2:0]  shadow_size = 3'd4;
  logic [31:0] shadow_thresh = 32'd1;

  function automatic wide_t elem_at(int r, int c, int n);
    wide_t v;
    v = $signed(shadow_store[r * n + c]);
    return v;
  endfunction

  // determinant of the k x k submatrix picked by rows and cols, by permutation sum
  function automatic wide_t minor_det(int k, int rows[4], int cols[4], int n);
    wide_t acc, prod;
    int p[4];
    int inv, t, i, j;
    bit ok;
    acc = 0;
    if (k == 0) return 1;
    for (t = 0; t < (1 << (2 * k)); t++) begin
      ok = 1'b1;
      for (i = 0; i < k; i++) begin
        p[i] = (t >> (2 * i)) & 3;
        if (p[i] >= k) ok = 1'b0;
      end
      inv = 0;
      for (i = 0; i < k; i++)
        for (j = i + 1; j < k; j++) begin
          if (p[i] == p[j]) ok = 1'b0;
          if (p[i] > p[j]) inv++;
        end
      if (ok) begin
        prod = 1;
        for (i = 0; i < k; i++) prod = prod * elem_at(rows[i], cols[p[i]], n);
        acc = inv[0] ? acc - prod : acc + prod;
      end
    end
    return acc;
  endfunction

  function automatic wide_t cofactor_of(int i, int j, int n);
    int rows[4], cols[4];
    int m, t;
    wide_t v;
    rows = '{0, 0, 0, 0};
    cols = '{0, 0, 0, 0};
    m = 0;
    for (t = 0; t < n; t++) if (t != i) begin rows[m] = t; m++; end
    m = 0;
    for (t = 0; t < n; t++) if (t != j) begin cols[m] = t; m++; end
    v = minor_det(n - 1, rows, cols, n);
    return ((i + j) % 2 == 1) ? -v : v;
  endfunction

  // full inverse of the loaded matrix, pushed as expected beats
  task automatic predict_inverse();
    int n, s, r, c;
    int ident[4];
    wide_t det, dq, ad, num, anum, q, lim;
    logic signed [63:0] det64;
    logic [63:0] mag;
    inverse_beat_t b;
    bit neg;
    ident = '{0, 1, 2, 3};
    n = shadow_size;
    if (n < 1) n = 1;
    if (n > MAX_DIM) n = MAX_DIM;
    det = minor_det(n, ident, ident, n);
    if (n == 1) dq = det <<< 16;
    else if (n == 2) dq = det;
    else begin
      s = 16 * n - 32;
      dq = (det + (wide_t'(1) <<< (s - 1))) >>> s;
    end
    if (dq > ((wide_t'(1) <<< 63) - 1)) det64 = 64'h7FFF_FFFF_FFFF_FFFF;
    else if (dq < -(wide_t'(1) <<< 63)) det64 = 64'h8000_0000_0000_0000;
    else det64 = dq[63:0];
    mag = det64[63] ? -det64 : det64;
    ad = (det < 0) ? -det : det;
    if (mag <= {32'd0, shadow_thresh} || det == 0) begin
      b = '{inv: 0, row: 0, col: 0, det: det64, status: STAT_SINGULAR, last: 1'b1};
      expected_inv.push_back(b);
      return;
    end
    for (r = 0; r < n; r++)
      for (c = 0; c < n; c++) begin
        num = cofactor_of(c, r, n) <<< 32;
        neg = (num < 0) != (det < 0);
        anum = (num < 0) ? -num : num;
        q = ((anum <<< 1) + ad) / (ad <<< 1);
        lim = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
        b.row = r[1:0];
        b.col = c[1:0];
        b.det = det64;
        b.last = (r == n - 1) && (c == n - 1);
        if (q > lim) begin
          b.inv = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
          b.status = STAT_SAT;
        end else begin
          b.inv = neg ? -q[31:0] : q[31:0];
          b.status = STAT_OK;
        end
        expected_inv.push_back(b);
      end
  endtask

  // element driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_element_value <= '0;
      in_final_element <= 1'b0;
    end else if (!start || !busy) begin
      if (pending_elems.size() > 0 && (steady || $urandom_range(99) >= 23)) begin
        in_element_value <= pending_elems[0].value;
        in_final_element <= pending_elems[0].last;
        void'(pending_elems.pop_front());
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predicts on each accepted element beat, checks each result beat
  always @(posedge clk) begin
    inverse_beat_t e;
    bit hit;
    hit = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        hit = 1'b1;
        if (cfg_index == CFG_MATRIX_SIZE) shadow_size = cfg_data[2:0];
        else shadow_thresh = cfg_data;
      end
      if (start && !busy) begin
        hit = 1'b1;
        if (shadow_count < STORE_DEPTH) begin
          shadow_store[shadow_count] = in_element_value;
          shadow_count++;
        end
        if (in_final_element) begin
          shadow_count = 0;
          predict_inverse();
        end
      end
      if (out_valid) begin
        hit = 1'b1;
        if (expected_inv.size() == 0) begin
          $error("unexpected result beat inverse_value=%0d", out_inverse_value);
          fail_count++;
        end else begin
          e = expected_inv.pop_front();
          if (out_inverse_value !== e.inv) begin
            $error("inverse_value exp %0d got %0d", e.inv, out_inverse_value);
            fail_count++;
          end
          if (out_row_index !== e.row) begin
            $error("row_index exp %0d got %0d", e.row, out_row_index);
            fail_count++;
          end
          if (out_column_index !== e.col) begin
            $error("column_index exp %0d got %0d", e.col, out_column_index);
            fail_count++;
          end
          if (out_determinant_value !== e.det) begin
            $error("determinant_value exp %0d got %0d", e.det, out_determinant_value);
            fail_count++;
          end
          if (out_status_code !== e.status) begin
            $error("status_code exp %0d got %0d", e.status, out_status_code);
            fail_count++;
          end
          if (out_final_result !== e.last) begin
            $error("final_result exp %0d got %0d", e.last, out_final_result);
            fail_count++;
          end
        end
      end
      quiet_cycles <= hit ? 0 : quiet_cycles + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_elem(logic signed [31:0] v, logic last);
    pending_elems.push_back('{value: v, last: last});
    elems_queued++;
  endtask

  // wait until the block has drained everything queued so far
  task automatic drain();
    while (pending_elems.size() > 0 || start || expected_inv.size() > 0 || busy)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_elem(int style);
    case (style)
      0: return $signed(32'($urandom_range(0, 32'h6_0000))) - 32'sh3_0000;
      1: return $urandom();
      default: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0001_0000;
          default: return 32'h0;
        endcase
      end
    endcase
  endfunction

  // matrix of len beats, the last one marked final
  task automatic queue_matrix(int len, int style);
    int k;
    for (k = 0; k < len; k++) queue_elem(rand_elem(style), k == len - 1);
  endtask

  initial begin
    int n, len, roll, k;
    logic [31:0] th;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MATRIX_SIZE;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity at reset size fills every slot
    for (k = 0; k < 16; k++) queue_elem((k % 5 == 0) ? 32'sh1_0000 : 32'sh0, k == 15);
    drain();

    // 1x1 extremes, zero is singular
    write_reg(CFG_MATRIX_SIZE, 32'd1);
    write_reg(CFG_THRESHOLD, 32'd0);
    queue_elem(32'sh8000_0000, 1'b1);
    queue_elem(32'sh7FFF_FFFF, 1'b1);
    queue_elem(32'sh0000_0001, 1'b1);
    queue_elem(32'sh0, 1'b1);
    drain();

    // 2x2 diagonal of small values, then a singular one
    write_reg(CFG_MATRIX_SIZE, 32'd2);
    queue_elem(32'sh0000_0100, 1'b0);
    queue_elem(32'sh0, 1'b0);
    queue_elem(32'sh0, 1'b0);
    queue_elem(-32'sh0000_0100, 1'b1);
    queue_elem(32'sh1_0000, 1'b0);
    queue_elem(32'sh2_0000, 1'b0);
    queue_elem(32'sh2_0000, 1'b0);
    queue_elem(32'sh4_0000, 1'b1);
    drain();

    // random part, one setting per matrix
    while (elems_queued < 150) begin
      roll = $urandom_range(99);
      steady = (elems_queued > 90 && elems_queued < 120);
      if (roll < 10) n = $urandom_range(7) - (($urandom_range(1) == 0) ? 0 : 3);
      else n = $urandom_range(1, 4);
      if (n < 0) n = 0;
      write_reg(CFG_MATRIX_SIZE, n);
      case ($urandom_range(5))
        0: th = 32'd0;
        1: th = 32'hFFFF_FFFF;
        2: th = $urandom();
        default: th = $urandom_range(0, 255);
      endcase
      write_reg(CFG_THRESHOLD, th);
      if (n < 1) n = 1;
      if (n > MAX_DIM) n = MAX_DIM;
      len = n * n;
      roll = $urandom_range(99);
      if (roll < 8) len = $urandom_range(1, n * n);
      else if (roll < 14) len = n * n + $urandom_range(1, 3);
      roll = $urandom_range(99);
      queue_matrix(len, (roll < 70) ? 0 : (roll < 90) ? 1 : 2);
      drain();
    end
    steady = 1'b0;
    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
